### hw/rtl/spt_pkg.sv
// shared types and constants for the polynomial temperature calibration pipeline
package spt_pkg;

    localparam int X_W    = 16;   // converter word after dropping the low byte
    localparam int H_W    = 47;   // signed Horner accumulator, 24 fraction bits
    localparam int M_W    = 20;   // multiplier operand, wide enough for 10*x
    localparam int P_W    = 62;   // signed product width
    localparam int DIV_SH = 5;    // 100000 = 2^5 * 3125
    localparam int NUM_W  = 56;   // magnitude after the power-of-two shift
    localparam int DIG_W  = 14;   // quotient bits per long-division step
    localparam int N_DIG  = NUM_W / DIG_W;
    localparam int REM_W  = 12;
    localparam int T_W    = REM_W + DIG_W;
    localparam int RCP_W  = 27;
    localparam int RCP_SH = 38;
    localparam int FRAC_W = 24;

    localparam logic [T_W-1:0]   DIV_ODD   = T_W'(3125);
    localparam logic [RCP_W-1:0] RECIP     = RCP_W'(87960930);  // floor(2^38 / 3125)
    localparam logic [P_W-1:0]   ROUND_ADD = P_W'(50000);
    localparam logic [H_W-1:0]   ROUND_OUT = H_W'(1) << (FRAC_W - 1);

    // beat travelling between Horner cells
    typedef struct packed {
        logic [X_W-1:0]        x;
        logic signed [H_W-1:0] h;
    } hs_t;

    // beat travelling between long-division steps
    typedef struct packed {
        logic              neg;
        logic [X_W-1:0]    x;
        logic [NUM_W-1:0]  num;
        logic [REM_W-1:0]  rem;
    } div_t;

endpackage

### hw/rtl/spt_digit.sv
// one long-division step by 3125: produces fourteen quotient bits over two stages
module spt_digit
    import spt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_vld,
    input  div_t in_d,
    output logic out_vld,
    output div_t out_d
);

    logic [T_W-1:0]         t_next;
    logic [T_W+RCP_W-1:0]   est_prod;
    logic [DIG_W-1:0]       qe_next;
    div_t                   d_next;

    logic                   vld1_reg;
    logic [T_W-1:0]         t_reg;
    logic [DIG_W-1:0]       qe_reg;
    div_t                   d1_reg;

    logic [T_W-1:0]         qd;
    logic [T_W-1:0]         r_raw;
    logic                   fix;
    logic [DIG_W-1:0]       q_fin;
    logic [T_W-1:0]         r_fin;
    div_t                   out_next;

    logic                   vld2_reg;
    div_t                   d2_reg;

    // estimate never exceeds the true digit and misses it by at most one
    assign t_next   = {in_d.rem, in_d.num[NUM_W-1 -: DIG_W]};
    assign est_prod = (T_W+RCP_W)'(t_next) * (T_W+RCP_W)'(RECIP);
    assign qe_next  = est_prod[RCP_SH +: DIG_W];

    always_comb
    begin
        d_next     = in_d;
        d_next.num = in_d.num << DIG_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg  <= t_next;
        qe_reg <= qe_next;
        d1_reg <= d_next;
    end

    assign qd    = T_W'(qe_reg) * DIV_ODD;
    assign r_raw = t_reg - qd;
    assign fix   = (r_raw >= DIV_ODD);
    assign q_fin = qe_reg + DIG_W'(fix);
    assign r_fin = fix ? (r_raw - DIV_ODD) : r_raw;

    always_comb
    begin
        out_next     = d1_reg;
        out_next.num = {d1_reg.num[NUM_W-1:DIG_W], q_fin};
        out_next.rem = r_fin[REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        d2_reg <= out_next;
    end

    assign out_vld = vld2_reg;
    assign out_d   = d2_reg;

endmodule

### hw/rtl/spt_cell.sv
// one Horner cell: h_out = coef + round(h_in * mult / 100000)
module spt_cell
    import spt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  hs_t                   in_s,
    input  logic [M_W-1:0]        mult,
    input  logic signed [H_W-1:0] coef,
    output logic                  out_vld,
    output hs_t                   out_s
);

    logic signed [H_W+M_W:0] prod_full;
    logic                    vld_a_reg;
    logic [P_W-1:0]          p_reg;
    logic [X_W-1:0]          x_a_reg;

    logic [P_W-1:0]          n_sum;
    logic [NUM_W:0]          m_val;
    div_t                    d_first;

    logic                    dv [0:N_DIG];
    div_t                    dc [0:N_DIG];

    logic [NUM_W-1:0]        q_mag;
    logic [H_W-1:0]          q_sgn;
    hs_t                     out_next;
    logic                    vld_o_reg;
    hs_t                     s_o_reg;

    assign prod_full = in_s.h * $signed({1'b0, mult});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            dv[0]     <= 1'b0;
            vld_o_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_vld;
            dv[0]     <= vld_a_reg;
            vld_o_reg <= dv[N_DIG];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= prod_full[P_W-1:0];
        x_a_reg <= in_s.x;
    end

    // floor by 32 is an arithmetic shift; a negative value is folded with
    // bitwise inversion so the divider only sees magnitudes
    assign n_sum = p_reg + ROUND_ADD;
    assign m_val = n_sum[P_W-1:DIV_SH];

    always_comb
    begin
        d_first.neg = m_val[NUM_W];
        d_first.x   = x_a_reg;
        d_first.num = m_val[NUM_W] ? ~m_val[NUM_W-1:0] : m_val[NUM_W-1:0];
        d_first.rem = '0;
    end

    always_ff @(posedge clk)
    begin
        dc[0] <= d_first;
    end

    for (genvar g = 0; g < N_DIG; g++)
    begin : g_dig
        spt_digit u_digit (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (dv[g]),
            .in_d    (dc[g]),
            .out_vld (dv[g+1]),
            .out_d   (dc[g+1])
        );
    end

    assign q_mag = dc[N_DIG].num;
    assign q_sgn = dc[N_DIG].neg ? ~q_mag[H_W-1:0] : q_mag[H_W-1:0];

    always_comb
    begin
        out_next.x = dc[N_DIG].x;
        out_next.h = coef + $signed(q_sgn);
    end

    always_ff @(posedge clk)
    begin
        s_o_reg <= out_next;
    end

    assign out_vld = vld_o_reg;
    assign out_s   = s_o_reg;

endmodule

### hw/rtl/sensor_poly_temperature.sv
// top level: fourth-order polynomial temperature calibration
//
// Input: pulse start with adc_raw; busy stays low, so one conversion word
// can be accepted on every clock edge. Bits 23..8 of adc_raw are used.
// Output: done is high for exactly one cycle with temperature_centi
// (hundredths of a degree, signed) and saturated; there is no backpressure.
// Pipeline: the input stage loads at the accepting edge, then four Horner
// cells of eleven stages each (multiply, fold, four two-stage long-division
// steps by 3125, coefficient add) and one output stage.
// Throughput: one word per cycle, every stage advances each cycle.
// Calibration words k0..k4 sit in an APB register file at byte addresses
// 0x00..0x10, low 16 bits of pwdata kept; pready is always high. Write them
// only while no conversion is in flight.
// Reset: rst_n clears all valid bits and the calibration words to zero.
module sensor_poly_temperature
    import spt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [23:0]        adc_raw,
    output logic               done,
    output logic signed [15:0] temperature_centi,
    output logic               saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [2:0] REG_K0 = 3'd0;
    localparam logic [2:0] REG_K1 = 3'd1;
    localparam logic [2:0] REG_K2 = 3'd2;
    localparam logic [2:0] REG_K3 = 3'd3;
    localparam logic [2:0] REG_K4 = 3'd4;
    localparam int N_CELL = 4;

    logic [15:0] k0_reg, k1_reg, k2_reg, k3_reg, k4_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    logic            in_vld_reg;
    logic [X_W-1:0]  x_reg;

    logic [N_CELL:0]       cv;
    hs_t                   cs [0:N_CELL];
    logic [M_W-1:0]        cmult [0:N_CELL-1];
    logic signed [H_W-1:0] ccoef [0:N_CELL-1];
    logic [17:0]           k0x3;

    logic [H_W-1:0]        rnd;
    logic [H_W-FRAC_W-1:0] centi_w;
    logic                  sat_hi, sat_lo;
    logic                  done_reg;
    logic signed [15:0]    temp_reg;
    logic                  sat_reg;

    // register file
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k0_reg <= '0;
            k1_reg <= '0;
            k2_reg <= '0;
            k3_reg <= '0;
            k4_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_K0:  k0_reg <= pwdata[15:0];
                REG_K1:  k1_reg <= pwdata[15:0];
                REG_K2:  k2_reg <= pwdata[15:0];
                REG_K3:  k3_reg <= pwdata[15:0];
                REG_K4:  k4_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_K0:  prdata = {16'b0, k0_reg};
            REG_K1:  prdata = {16'b0, k1_reg};
            REG_K2:  prdata = {16'b0, k2_reg};
            REG_K3:  prdata = {16'b0, k3_reg};
            REG_K4:  prdata = {16'b0, k4_reg};
            default: prdata = '0;
        endcase
    end

    // input stage
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= adc_raw[23:8];
    end

    // Horner seed and per-cell constants, all scaled by 2^24
    assign cv[0]   = in_vld_reg;
    assign cs[0].x = x_reg;
    assign cs[0].h = $signed(H_W'(0) - H_W'({k4_reg, 25'b0}));

    assign k0x3 = {2'b0, k0_reg} + {1'b0, k0_reg, 1'b0};

    assign ccoef[0] = $signed(H_W'({k3_reg, 26'b0}));
    assign ccoef[1] = $signed(H_W'(0) - H_W'({k2_reg, 25'b0}));
    assign ccoef[2] = $signed(H_W'({k1_reg, 24'b0}));
    assign ccoef[3] = $signed(H_W'(0) - H_W'({k0x3, 23'b0}));

    assign cmult[0] = M_W'(cs[0].x);
    assign cmult[1] = M_W'(cs[1].x);
    assign cmult[2] = M_W'(cs[2].x);
    // last step divides by 10000: fold the factor ten into the multiplier
    assign cmult[3] = M_W'({cs[3].x, 3'b0}) + M_W'({cs[3].x, 1'b0});

    for (genvar g = 0; g < N_CELL; g++)
    begin : g_cell
        spt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (cv[g]),
            .in_s    (cs[g]),
            .mult    (cmult[g]),
            .coef    (ccoef[g]),
            .out_vld (cv[g+1]),
            .out_s   (cs[g+1])
        );
    end

    // round off the fraction and clip to 16 bits
    assign rnd     = cs[N_CELL].h + ROUND_OUT;
    assign centi_w = rnd[H_W-1:FRAC_W];
    assign sat_hi  = !centi_w[H_W-FRAC_W-1] && (|centi_w[H_W-FRAC_W-2:15]);
    assign sat_lo  = centi_w[H_W-FRAC_W-1] && !(&centi_w[H_W-FRAC_W-2:15]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cv[N_CELL];
    end

    always_ff @(posedge clk)
    begin
        if (sat_hi)
            temp_reg <= 16'sh7FFF;
        else if (sat_lo)
            temp_reg <= -16'sh8000;
        else
            temp_reg <= $signed(centi_w[15:0]);
        sat_reg <= sat_hi || sat_lo;
    end

    assign done              = done_reg;
    assign temperature_centi = temp_reg;
    assign saturated         = sat_reg;

endmodule

### bench/tb_top.sv
// self-checking bench for the polynomial temperature calibration block
`timescale 1ns / 100ps

module tb_top;

    localparam int     N_WORDS     = 5;      // calibration words k0..k4
    localparam int     LAST_SLOT   = 7;      // highest index reachable on paddr
    localparam int     IDLE_LIMIT  = 2000;
    localparam int     TAIL_CYCLES = 60;     // pipeline is 46 deep
    localparam int     RAND_PHASES = 7;
    localparam int     PHASE_ITEMS = 147;
    localparam longint FRAC_ONE    = 64'sd16777216;
    localparam longint FRAC_HALF   = 64'sd8388608;
    localparam longint STEP_DIV    = 64'sd100000;
    localparam longint LAST_DIV    = 64'sd10000;
    localparam logic signed [15:0] TEMP_HI = 16'sh7FFF;
    localparam logic signed [15:0] TEMP_LO = 16'sh8000;

    // a typical factory calibration set, k4 down to k0
    localparam logic [N_WORDS-1:0][15:0] TYP_WORDS =
        {16'd28446, 16'd24926, 16'd36016, 16'd32791, 16'd40781};

    typedef struct packed {
        logic signed [15:0] temp;
        logic               sat;
    } temp_beat_t;

    typedef struct packed {
        logic [15:0]        k0;
        logic [15:0]        k1;
        logic [15:0]        k2;
        logic [15:0]        k3;
        logic [15:0]        k4;
        logic [23:0]        raw;
        logic               given;
        logic signed [15:0] t;
        logic               s;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // reset values, every coefficient zero
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'h000000, 1'b1, 16'sd0, 1'b0},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'hFFFFFF, 1'b1, 16'sd0, 1'b0},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'h0000FF, 1'b1, 16'sd0, 1'b0},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'h800000, 1'b1, 16'sd0, 1'b0},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'h7FFF00, 1'b1, 16'sd0, 1'b0},
        // one term at full scale at a time
        '{16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 24'h000000, 1'b1, TEMP_LO, 1'b1},
        '{16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 24'hFFFFFF, 1'b1, TEMP_LO, 1'b1},
        '{16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 24'h0000FF, 1'b1, 16'sd0, 1'b0},
        '{16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 24'hFFFFFF, 1'b1, TEMP_HI, 1'b1},
        '{16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 24'h000100, 1'b0, 16'sd0, 1'b0},
        '{16'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 24'hFFFFFF, 1'b1, TEMP_LO, 1'b1},
        '{16'd0, 16'd0, 16'd0, 16'd65535, 16'd0, 24'hFFFFFF, 1'b1, TEMP_HI, 1'b1},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 24'hFFFFFF, 1'b1, TEMP_LO, 1'b1},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 24'h0000AB, 1'b1, 16'sd0, 1'b0},
        // realistic part
        '{16'd40781, 16'd32791, 16'd36016, 16'd24926, 16'd28446, 24'h5A0000,
          1'b0, 16'sd0, 1'b0},
        '{16'd40781, 16'd32791, 16'd36016, 16'd24926, 16'd28446, 24'h6C1234,
          1'b0, 16'sd0, 1'b0},
        '{16'd40781, 16'd32791, 16'd36016, 16'd24926, 16'd28446, 24'h000000,
          1'b1, TEMP_LO, 1'b1},
        '{16'd40781, 16'd32791, 16'd36016, 16'd24926, 16'd28446, 24'h7FFFFF,
          1'b0, 16'sd0, 1'b0},
        '{16'd40781, 16'd32791, 16'd36016, 16'd24926, 16'd28446, 24'hFFFFFF,
          1'b0, 16'sd0, 1'b0},
        // everything at full scale
        '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 24'h000000,
          1'b1, TEMP_LO, 1'b1},
        '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 24'h800000,
          1'b0, 16'sd0, 1'b0},
        '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 24'hFFFFFF,
          1'b0, 16'sd0, 1'b0},
        // small offsets: exact negative value and a half rounded up, then a mixed set
        '{16'd2, 16'd1, 16'd0, 16'd0, 16'd0, 24'h000000, 1'b1, -16'sd3, 1'b0},
        '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 24'h000000, 1'b1, -16'sd1, 1'b0},
        '{16'd1000, 16'd30000, 16'd1000, 16'd1000, 16'd1000, 24'h123456,
          1'b0, 16'sd0, 1'b0}
    };

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [23:0]        adc_raw;
    logic               done;
    logic signed [15:0] temperature_centi;
    logic               saturated;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logic [N_WORDS-1:0][15:0] cal_set = '0;
    temp_beat_t               pending_temps [$];
    temp_beat_t               want;
    int                       fail_count  = 0;
    int                       idle_count  = 0;
    int                       burst_left  = 0;
    bit                       gaps_on     = 1'b1;

    sensor_poly_temperature dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .adc_raw           (adc_raw),
        .done              (done),
        .temperature_centi (temperature_centi),
        .saturated         (saturated),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint floor_div(input longint v, input longint d);
        longint q;
        longint r;
        q = v / d;
        r = v % d;
        if (r < 0)
            q = q - 1;
        return q;
    endfunction

    // nearest integer, halves go up
    function automatic longint round_near(input longint v, input longint d);
        return floor_div(v + d / 2, d);
    endfunction

    function automatic temp_beat_t calibrate(input logic [23:0] raw);
        longint     x;
        longint     h;
        longint     c;
        longint     centi;
        temp_beat_t r;
        x = {48'd0, raw[23:8]};
        h = -2 * longint'(cal_set[4]) * FRAC_ONE;
        h = 4 * longint'(cal_set[3]) * FRAC_ONE + round_near(h * x, STEP_DIV);
        h = -2 * longint'(cal_set[2]) * FRAC_ONE + round_near(h * x, STEP_DIV);
        h = longint'(cal_set[1]) * FRAC_ONE + round_near(h * x, STEP_DIV);
        c = round_near(h * x, LAST_DIV) - 3 * longint'(cal_set[0]) * FRAC_HALF;
        centi = round_near(c, FRAC_ONE);
        if (centi > 32767) begin
            r.temp = TEMP_HI;
            r.sat  = 1'b1;
        end
        else if (centi < -32768) begin
            r.temp = TEMP_LO;
            r.sat  = 1'b1;
        end
        else begin
            r.temp = centi[15:0];
            r.sat  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [23:0] pick_raw();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return {16'h0000, 8'($urandom)};
            1:       return {16'hFFFF, 8'($urandom)};
            2, 3, 4, 5: return {16'($urandom_range(16'h4000, 16'hA000)), 8'($urandom)};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start   = 1'b0;
            adc_raw = 24'($urandom);
        end
    endtask

    task automatic apb_xfer(input bit wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = 5'(4 * idx);
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_temps.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_coeffs(input logic [N_WORDS-1:0][15:0] w);
        logic [31:0] rd;
        int          i;
        idle_cycles(1);
        wait_drained();
        repeat (4) @(posedge clk);
        // upper pwdata bits are junk and must be dropped
        for (i = 0; i < N_WORDS; i++)
            apb_xfer(1'b1, i, {16'($urandom), w[i]}, rd);
        // unmapped slot must not disturb anything
        apb_xfer(1'b1, $urandom_range(N_WORDS, LAST_SLOT), $urandom, rd);
        for (i = 0; i < N_WORDS; i++)
        begin
            apb_xfer(1'b0, i, 32'd0, rd);
            if (rd[15:0] !== w[i]) begin
                $error("coeff_k%0d readback: expected %0h, actual %0h", i, w[i], rd[15:0]);
                fail_count++;
            end
        end
        cal_set = w;
    endtask

    task automatic feed(input logic [23:0] raw, input bit given, input temp_beat_t given_val);
        if (burst_left == 0) begin
            if (gaps_on)
                idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        start   = 1'b1;
        adc_raw = raw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_temps.push_back(given ? given_val : calibrate(raw));
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (pending_temps.size() == 0) begin
                $error("unexpected beat: temperature_centi %0d saturated %0b",
                       temperature_centi, saturated);
                fail_count++;
            end
            else begin
                want = pending_temps.pop_front();
                if (temperature_centi !== want.temp) begin
                    $error("temperature_centi: expected %0d, actual %0d",
                           want.temp, temperature_centi);
                    fail_count++;
                end
                if (saturated !== want.sat) begin
                    $error("saturated: expected %0b, actual %0b", want.sat, saturated);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable) || !rst_n)
            idle_count <= 0;
        else begin
            idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int                       r;
        int                       p;
        int                       i;
        int                       v;
        logic [N_WORDS-1:0][15:0] w;
        temp_beat_t               tv;

        rst_n   = 1'b0;
        start   = 1'b0;
        adc_raw = 24'd0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 5'd0;
        pwdata  = 32'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
        begin
            w = {DIR_TAB[r].k4, DIR_TAB[r].k3, DIR_TAB[r].k2, DIR_TAB[r].k1, DIR_TAB[r].k0};
            if (w !== cal_set)
                load_coeffs(w);
            tv.temp = DIR_TAB[r].t;
            tv.sat  = DIR_TAB[r].s;
            feed(DIR_TAB[r].raw, DIR_TAB[r].given, tv);
        end

        for (p = 0; p < RAND_PHASES; p++)
        begin
            for (i = 0; i < N_WORDS; i++)
            begin
                if (p % 2 == 0) begin
                    // near a real part, so most temperatures stay in range
                    v = int'(TYP_WORDS[i]) + $urandom_range(0, 8191) - 4096;
                    w[i] = 16'(v);
                end
                else begin
                    case ($urandom_range(0, 7))
                        0:       w[i] = 16'd0;
                        1:       w[i] = 16'hFFFF;
                        default: w[i] = 16'($urandom);
                    endcase
                end
            end
            load_coeffs(w);
            gaps_on = (p % 3 != 2);
            burst_left = 0;
            tv = '0;
            for (i = 0; i < PHASE_ITEMS; i++)
                feed(pick_raw(), 1'b0, tv);
        end

        idle_cycles(1);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
